/* rtl/core/sitd_pkg.sv */
`default_nettype none

package sitd_pkg;

  localparam int VALUE_W    = 32;
  localparam int NUM_DIGITS = 10;
  localparam int DIGIT_W    = 4;
  localparam int CHAR_W     = 8;
  localparam int BIT_CNT_W  = $clog2(VALUE_W);
  localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

  localparam logic [DIGIT_W-1:0] DIGIT_ADJ_MIN = 4'd5;
  localparam logic [DIGIT_W-1:0] DIGIT_ADJ_ADD = 4'd3;

  typedef struct packed {
    logic clear;
    logic conv;
    logic shift;
  } cell_ctrl_t;

endpackage

`default_nettype wire

/* rtl/core/sitd_cell.sv */
`default_nettype none

module sitd_cell
  import sitd_pkg::*;
(
  input  wire                 clk,
  input  wire  cell_ctrl_t    ctrl,
  input  wire                 bit_in,
  input  wire  [DIGIT_W-1:0]  digit_in,
  output logic                carry_out,
  output logic [DIGIT_W-1:0]  digit_out
);

  logic [DIGIT_W-1:0] digit_r;
  logic [DIGIT_W-1:0] digit_nxt;
  logic [DIGIT_W-1:0] adj;

  // add-3 correction before the shift
  assign adj       = (digit_r >= DIGIT_ADJ_MIN) ? (digit_r + DIGIT_ADJ_ADD) : digit_r;
  assign carry_out = adj[DIGIT_W-1];
  assign digit_out = digit_r;

  always_comb begin
    priority if (ctrl.clear) begin
      digit_nxt = '0;
    end else if (ctrl.conv) begin
      digit_nxt = {adj[DIGIT_W-2:0], bit_in};
    end else if (ctrl.shift) begin
      digit_nxt = digit_in;
    end else begin
      digit_nxt = digit_r;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

endmodule

`default_nettype wire

/* rtl/core/signed_int_to_decimal_text.sv */
`default_nettype none

// Signed 32-bit integer to decimal ASCII text.
// Input: pulse start with in_value while busy is low; the transaction is taken
// at that edge and busy rises on the next cycle.
// Output: one character per out_strobe pulse, most significant first; a
// negative value begins with '-', zero gives a single '0', no leading zeros.
// out_last marks the final character of the value. Each character is present
// for exactly one cycle; the receiver cannot stall the block.
// Sequence: while busy is high the block makes 32 shift steps of the
// magnitude through the row of ten decimal digit cells, takes a sign step,
// then shifts the digits out of the top cell, leading zeros being dropped.
// A new value may be started in the cycle the last character is shown;
// busy stays high and no new value is taken before then.
// Reset: rst_n is synchronous, active low; it returns the controller to idle
// and drops out_strobe; a conversion in flight is abandoned.

module signed_int_to_decimal_text
  import sitd_pkg::*;
(
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  output logic               busy,
  input  wire  [VALUE_W-1:0] in_value,
  output logic               out_strobe,
  output logic [CHAR_W-1:0]  out_character,
  output logic               out_last
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_CONV   = 2'd1;
  localparam logic [1:0] ST_SIGN   = 2'd2;
  localparam logic [1:0] ST_DIGITS = 2'd3;

  logic [1:0]           state_r,   state_nxt;
  logic [VALUE_W-1:0]   mag_r,     mag_nxt;
  logic                 neg_r,     neg_nxt;
  logic [BIT_CNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [DIG_CNT_W-1:0] dig_cnt_r, dig_cnt_nxt;
  logic                 started_r, started_nxt;
  logic                 strobe_r,  strobe_nxt;
  logic [CHAR_W-1:0]    char_r,    char_nxt;
  logic                 last_r,    last_nxt;

  cell_ctrl_t           ctrl;
  logic                 accept;
  logic                 emit_digit;
  logic [DIGIT_W-1:0]   top_digit;
  logic [NUM_DIGITS-1:0] carry;
  logic [DIGIT_W-1:0]   digit [NUM_DIGITS];

  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign top_digit = digit[NUM_DIGITS-1];

  assign ctrl.clear = accept;
  assign ctrl.conv  = (state_r == ST_CONV);
  assign ctrl.shift = (state_r == ST_DIGITS);

  // digit row, least significant cell first
  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    if (i == 0) begin : g_first
      sitd_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .bit_in    (mag_r[VALUE_W-1]),
        .digit_in  ({DIGIT_W{1'b0}}),
        .carry_out (carry[i]),
        .digit_out (digit[i])
      );
    end else begin : g_rest
      sitd_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .bit_in    (carry[i-1]),
        .digit_in  (digit[i-1]),
        .carry_out (carry[i]),
        .digit_out (digit[i])
      );
    end
  end

  assign emit_digit = started_r || (top_digit != '0) ||
                      (dig_cnt_r == DIG_CNT_W'(1));

  always_comb begin
    state_nxt   = state_r;
    mag_nxt     = mag_r;
    neg_nxt     = neg_r;
    bit_cnt_nxt = bit_cnt_r;
    dig_cnt_nxt = dig_cnt_r;
    started_nxt = started_r;
    strobe_nxt  = 1'b0;
    char_nxt    = char_r;
    last_nxt    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          neg_nxt     = in_value[VALUE_W-1];
          mag_nxt     = in_value[VALUE_W-1] ? (VALUE_W'(0) - in_value) : in_value;
          bit_cnt_nxt = BIT_CNT_W'(VALUE_W - 1);
          state_nxt   = ST_CONV;
        end
      end
      ST_CONV: begin
        mag_nxt     = {mag_r[VALUE_W-2:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r - BIT_CNT_W'(1);
        if (bit_cnt_r == '0) begin
          state_nxt = ST_SIGN;
        end
      end
      ST_SIGN: begin
        strobe_nxt  = neg_r;
        char_nxt    = CHAR_MINUS;
        dig_cnt_nxt = DIG_CNT_W'(NUM_DIGITS);
        started_nxt = 1'b0;
        state_nxt   = ST_DIGITS;
      end
      ST_DIGITS: begin
        if (emit_digit) begin
          strobe_nxt  = 1'b1;
          char_nxt    = CHAR_ZERO + CHAR_W'(top_digit);
          last_nxt    = (dig_cnt_r == DIG_CNT_W'(1));
          started_nxt = 1'b1;
        end
        dig_cnt_nxt = dig_cnt_r - DIG_CNT_W'(1);
        if (dig_cnt_r == DIG_CNT_W'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      strobe_r <= 1'b0;
      last_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
      last_r   <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r     <= mag_nxt;
    neg_r     <= neg_nxt;
    bit_cnt_r <= bit_cnt_nxt;
    dig_cnt_r <= dig_cnt_nxt;
    started_r <= started_nxt;
    char_r    <= char_nxt;
  end

  assign out_strobe    = strobe_r;
  assign out_character = char_r;
  assign out_last      = last_r;

`ifndef ASSERT_OFF
  a_strobe_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("character strobed without a conversion in progress");

  a_last_with_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |-> out_strobe)
    else $error("last flag without a character");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_last) |=> !out_strobe)
    else $error("character right after the last one");

  a_minus_first: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_character == CHAR_MINUS)) |-> !out_last)
    else $error("sign emitted as the final character");
`endif

endmodule

`default_nettype wire

/* verif/signed_int_to_decimal_text_tb.sv */
module signed_int_to_decimal_text_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sitd_pkg::*;

  localparam int RADIX       = 10;
  localparam int STALL_LIMIT = 1000;
  localparam int TAIL_CYCLES = 50;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_char_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic [VALUE_W-1:0] in_value = '0;
  logic               busy;
  logic               out_strobe;
  logic [CHAR_W-1:0]  out_character;
  logic               out_last;

  text_char_t text_q[$];
  int         mismatch_count = 0;
  int         stall_cycles = 0;

  signed_int_to_decimal_text u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_value     (in_value),
    .out_strobe   (out_strobe),
    .out_character(out_character),
    .out_last     (out_last)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input int expv, input int gotv);
    $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, expv, gotv);
    mismatch_count++;
  endtask

  // decimal text of one signed value, most significant digit first
  function automatic void predict_text(input logic [VALUE_W-1:0] raw);
    logic               neg;
    logic [VALUE_W-1:0] mag;
    logic [DIGIT_W-1:0] digits[NUM_DIGITS];
    int                 nd;
    text_char_t         c;
    neg = raw[VALUE_W-1];
    mag = neg ? (VALUE_W'(0) - raw) : raw;
    nd  = 0;
    do begin
      digits[nd] = DIGIT_W'(mag % RADIX);
      mag = mag / RADIX;
      nd++;
    end while (mag != 0 && nd < NUM_DIGITS);
    if (neg) begin
      c.ch   = CHAR_MINUS;
      c.last = 1'b0;
      text_q.push_back(c);
    end
    for (int i = nd - 1; i >= 0; i--) begin
      c.ch   = CHAR_ZERO + CHAR_W'(digits[i]);
      c.last = (i == 0);
      text_q.push_back(c);
    end
  endfunction

  // start stays high on return so back-to-back transactions need no toggle
  task automatic send_value(input logic [VALUE_W-1:0] v);
    start    <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (busy !== 1'b0);
    predict_text(v);
  endtask

  task automatic maybe_idle(input int idle_pct);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start    <= 1'b0;
      in_value <= $urandom;
      repeat ($urandom_range(1, 50)) @(posedge clk);
    end
  endtask

  function automatic logic [VALUE_W-1:0] rand_value();
    logic [VALUE_W-1:0] v;
    int unsigned        p;
    p = 1;
    case ($urandom_range(3))
      0: v = $urandom;
      1: v = $urandom_range(20000);
      2: begin
        repeat ($urandom_range(1, 9)) p = p * RADIX;
        v = p - $urandom_range(1);
      end
      default: v = $urandom >> $urandom_range(31);
    endcase
    if ($urandom_range(1)) v = VALUE_W'(0) - v;
    return v;
  endfunction

  task automatic test_extremes();
    logic [VALUE_W-1:0] vals[$];
    vals = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
             -32'sd7, 32'd12345, -32'sd98765, 32'd999999999, 32'd1000000000,
             -32'sd999999999, -32'sd1000000000, 32'h7fffffff, 32'h80000000,
             32'h80000001, 32'h55555555, 32'haaaaaaaa, 32'd4294967295,
             32'd1234567890, -32'sd2000000000};
    foreach (vals[i]) send_value(vals[i]);
  endtask

  task automatic test_random_values(input int count, input int idle_pct);
    repeat (count) begin
      send_value(rand_value());
      maybe_idle(idle_pct);
    end
  endtask

  task automatic test_pause_until_drained();
    repeat (3) send_value(rand_value());
    start <= 1'b0;
    while (text_q.size() != 0) @(posedge clk);
    repeat (4) send_value(rand_value());
  endtask

  always @(posedge clk) begin
    text_char_t e;
    if (rst_n && out_strobe === 1'b1) begin
      if (text_q.size() == 0) begin
        report_mismatch("unexpected character", -1, int'(out_character));
      end else begin
        e = text_q.pop_front();
        if (out_character !== e.ch)
          report_mismatch("character", int'(e.ch), int'(out_character));
        if (out_last !== e.last) report_mismatch("last", int'(e.last), int'(out_last));
      end
    end
  end

  always @(posedge clk) begin
    if ((start && busy === 1'b0 && rst_n) || out_strobe === 1'b1) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_random_values(120, 9);
    test_random_values(120, 50);
    test_pause_until_drained();
    test_random_values(110, 0);
    start <= 1'b0;
    while (text_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
